// ===== design/fatlb_pkg.sv =====
`default_nettype none

package fatlb_pkg;

   localparam int VPN_W = 36;
   localparam int PPN_W = 20;
   localparam int OFS_W = 12;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_FLUSH     = 1'b1;

   // search token and what it has found so far, handed from cell to cell
   typedef struct packed {
      logic             tok;
      logic             found;
      logic [PPN_W-1:0] ppn;
   } fatlb_link_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             flush;
      logic             touch;
      logic             fill;
      logic [VPN_W-1:0] vpn;
      logic [PPN_W-1:0] wppn;
   } fatlb_upd_type;

   typedef struct packed {
      logic             hit;
      logic [PPN_W-1:0] ppn;
      logic [OFS_W-1:0] ofs;
      logic             status;
   } fatlb_res_type;

endpackage

`default_nettype wire

// ===== design/fatlb_if.sv =====
`default_nettype none

interface fatlb_req_if;
   import fatlb_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [VPN_W-1:0] vpn;
   logic [OFS_W-1:0] va_offset;
   logic [PPN_W-1:0] walk_ppn;
   logic             walk_ok;

   modport source (output valid, output op, output vpn, output va_offset,
                   output walk_ppn, output walk_ok, input ready);
   modport sink (input valid, input op, input vpn, input va_offset,
                 input walk_ppn, input walk_ok, output ready);
endinterface

interface fatlb_rsp_if;
   import fatlb_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [PPN_W-1:0] phys_page;
   logic [OFS_W-1:0] phys_offset;
   logic             status;

   modport source (output valid, output hit, output phys_page, output phys_offset,
                   output status, input ready);
   modport sink (input valid, input hit, input phys_page, input phys_offset,
                 input status, output ready);
endinterface

`default_nettype wire

// ===== design/fully_assoc_tlb_lru.sv =====
// channel   dir  handshake       payload
// req_chan  in   valid / ready   op, vpn, va_offset, walk_ppn, walk_ok
// rsp_chan  out  valid / ready   hit, phys_page, phys_offset, status
//
// a translate item walks a token down the row of LINES cells, one cell a cycle,
// so its result is formed as the token leaves the last cell; a flush result goes straight to the pending register
// one item at a time: req_chan.ready is low from acceptance until the result
// has moved into the output register, which holds it while rsp_chan stalls
// reset is synchronous; after it all entries are invalid and line k has lru rank k
`default_nettype none

module fully_assoc_tlb_lru #(
   parameter int LINES = 128
) (
   input  logic              clock,
   input  logic              reset,
   fatlb_req_if.sink         req_chan,
   fatlb_rsp_if.source       rsp_chan
);
   import fatlb_pkg::*;

   localparam int RANK_W = (LINES > 1) ? $clog2(LINES) : 1;

   logic              busy_ff, busy_in;
   logic              start_ff, start_in;
   logic [VPN_W-1:0]  vpn_ff, vpn_in;
   logic [OFS_W-1:0]  ofs_ff, ofs_in;
   logic [PPN_W-1:0]  wppn_ff, wppn_in;
   logic              wok_ff, wok_in;
   logic              pend_valid_ff, pend_valid_in;
   fatlb_res_type     pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fatlb_res_type     rsp_ff, rsp_in;

   logic              accept, take_tr, take_fl, done, move;
   fatlb_link_type    seed;
   fatlb_link_type    link [LINES];
   logic [RANK_W-1:0] link_rank [LINES];
   logic [LINES-1:0]  tok_vec;
   fatlb_upd_type     upd;
   fatlb_link_type    last;
   logic [RANK_W-1:0] last_rank;

   assign req_chan.ready = !busy_ff && !pend_valid_ff;
   assign accept  = req_chan.valid && req_chan.ready;
   assign take_tr = accept && (req_chan.op == OP_TRANSLATE);
   assign take_fl = accept && (req_chan.op == OP_FLUSH);

   assign last      = link[LINES-1];
   assign last_rank = link_rank[LINES-1];
   assign done      = last.tok;

   assign seed.tok   = start_ff;
   assign seed.found = 1'b0;
   assign seed.ppn   = '0;

   assign upd.flush = take_fl;
   assign upd.touch = done && last.found;
   assign upd.fill  = done && !last.found && wok_ff;
   assign upd.vpn   = vpn_ff;
   assign upd.wppn  = wppn_ff;

   // row of cells
   for (genvar i = 0; i < LINES; i++) begin : g_cell
      fatlb_link_type    cin;
      logic [RANK_W-1:0] cin_rank;
      if (i == 0) begin : g_head
         assign cin      = seed;
         assign cin_rank = '0;
      end else begin : g_body
         assign cin      = link[i-1];
         assign cin_rank = link_rank[i-1];
      end
      fatlb_cell #(
         .RANK_W     (RANK_W),
         .RESET_RANK (RANK_W'(i)),
         .MAX_RANK   (RANK_W'(LINES - 1))
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .link_in       (cin),
         .link_rank_in  (cin_rank),
         .link_out      (link[i]),
         .link_rank_out (link_rank[i]),
         .upd           (upd),
         .upd_rank      (last_rank)
      );
      assign tok_vec[i] = link[i].tok;
   end

   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      busy_in  = busy_ff;
      start_in = take_tr;
      vpn_in   = vpn_ff;
      ofs_in   = ofs_ff;
      wppn_in  = wppn_ff;
      wok_in   = wok_ff;
      if (take_tr) begin
         busy_in = 1'b1;
         vpn_in  = req_chan.vpn;
         ofs_in  = req_chan.va_offset;
         wppn_in = req_chan.walk_ppn;
         wok_in  = req_chan.walk_ok;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (done) begin
         pend_valid_in  = 1'b1;
         pend_in.hit    = last.found;
         pend_in.ofs    = ofs_ff;
         pend_in.status = !last.found && !wok_ff;
         if (last.found) begin
            pend_in.ppn = last.ppn;
         end else if (wok_ff) begin
            pend_in.ppn = wppn_ff;
         end else begin
            pend_in.ppn = '0;
         end
      end else if (take_fl) begin
         pend_valid_in = 1'b1;
         pend_in       = '0;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         start_ff      <= start_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vpn_ff  <= vpn_in;
      ofs_ff  <= ofs_in;
      wppn_ff <= wppn_in;
      wok_ff  <= wok_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_ff.hit;
   assign rsp_chan.phys_page   = rsp_ff.ppn;
   assign rsp_chan.phys_offset = rsp_ff.ofs;
   assign rsp_chan.status      = rsp_ff.status;

   // at most one search token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token in the row");

   // end of a search ends the busy phase
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff)
      else $error("still busy after search end");

   // pending slot stays empty while a search runs
   a_busy_pend: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pend_valid_ff)
      else $error("pending result during search");

   // a hit never reports a walk error
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.hit) |-> !rsp_chan.status)
      else $error("hit with error status");

endmodule

`default_nettype wire

// ===== design/fatlb_cell.sv =====
`default_nettype none

module fatlb_cell #(
   parameter int              RANK_W     = 7,
   parameter logic [RANK_W-1:0] RESET_RANK = '0,
   parameter logic [RANK_W-1:0] MAX_RANK   = '1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fatlb_pkg::fatlb_link_type  link_in,
   input  logic [RANK_W-1:0]          link_rank_in,
   output fatlb_pkg::fatlb_link_type  link_out,
   output logic [RANK_W-1:0]          link_rank_out,
   input  fatlb_pkg::fatlb_upd_type   upd,
   input  logic [RANK_W-1:0]          upd_rank
);
   import fatlb_pkg::*;

   logic              valid_ff, valid_in;
   logic [VPN_W-1:0]  tag_ff, tag_in;
   logic [PPN_W-1:0]  ppn_ff, ppn_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              tok_ff, tok_in;
   logic              found_ff, found_in;
   logic [PPN_W-1:0]  fppn_ff, fppn_in;
   logic [RANK_W-1:0] frank_ff, frank_in;
   logic              match;

   assign match = valid_ff && (tag_ff == upd.vpn);

   // search stage: first match along the chain wins
   always_comb begin
      tok_in   = link_in.tok;
      found_in = link_in.tok && (link_in.found || match);
      if (link_in.tok && !link_in.found && match) begin
         fppn_in  = ppn_ff;
         frank_in = rank_ff;
      end else begin
         fppn_in  = link_in.ppn;
         frank_in = link_rank_in;
      end
   end

   // entry and lru rank update
   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      ppn_in   = ppn_ff;
      rank_in  = rank_ff;
      if (upd.flush) begin
         valid_in = 1'b0;
      end else if (upd.fill) begin
         if (rank_ff == '0) begin
            valid_in = 1'b1;
            tag_in   = upd.vpn;
            ppn_in   = upd.wppn;
            rank_in  = MAX_RANK;
         end else begin
            rank_in = rank_ff - 1'b1;
         end
      end else if (upd.touch) begin
         if (rank_ff == upd_rank) begin
            rank_in = MAX_RANK;
         end else if (rank_ff > upd_rank) begin
            rank_in = rank_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RESET_RANK;
         tok_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         tok_ff   <= tok_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      ppn_ff   <= ppn_in;
      fppn_ff  <= fppn_in;
      frank_ff <= frank_in;
   end

   assign link_out.tok   = tok_ff;
   assign link_out.found = found_ff;
   assign link_out.ppn   = fppn_ff;
   assign link_rank_out  = frank_ff;

endmodule

`default_nettype wire
